// File: sv/carmichael_number_tester_top_defines.svh
// assertion macros for the carmichael number tester checker
// expects clk and rst_n in the scope where a macro is used
`ifndef CARMICHAEL_NUMBER_TESTER_TOP_DEFINES_SVH
`define CARMICHAEL_NUMBER_TESTER_TOP_DEFINES_SVH

// same-cycle implication
`define CMT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("carmichael tester check failed");

// next-cycle implication
`define CMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("carmichael tester check failed");

`endif

// File: sv/cmt_pkg.sv
// shared constants, types and control structs of the carmichael number tester
// no dependencies
`timescale 1ns / 1ps

package cmt_pkg;

    localparam int NUMBER_BITS       = 20;
    localparam int COUNT_BITS        = 3;
    localparam int CNT_INT_BITS      = 4;
    localparam int QSQ_BITS          = NUMBER_BITS + 2;
    localparam int STEP_BITS         = $clog2(NUMBER_BITS + 1);
    localparam int MIN_PRIME_FACTORS = 3;
    localparam int COUNT_MAX         = 7;
    localparam int FIRST_DIVISOR     = 2;

    typedef enum logic [1:0] {
        DIV_REST_Q,
        DIV_NM1_QM1,
        DIV_NM1_RESTM1
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_TEST,
        S_DIV1,
        S_START2,
        S_DIV2,
        S_DIV3,
        S_LAST,
        S_DIV4,
        S_EMIT,
        S_EMIT_ZERO
    } state_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_quot;
        logic     next_q;
        logic     count_inc;
        logic     korselt_chk;
        logic     emit;
        logic     emit_zero;
    } cmd_t;

    typedef struct packed {
        logic n_lt2;
        logic qsq_gt_rest;
        logic rest_gt1;
        logic div_done;
        logic rem_zero;
        logic out_free;
    } stat_t;

endpackage

// File: sv/cmt_if.sv
// valid/ready channel interfaces: candidate in, test result out
// depends on cmt_pkg
`timescale 1ns / 1ps

interface cmt_cand_if import cmt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [NUMBER_BITS-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface cmt_result_if import cmt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  is_carmichael;
    logic                  is_squarefree;
    logic [COUNT_BITS-1:0] prime_factor_count;

    modport source (output valid, output is_carmichael, output is_squarefree,
                    output prime_factor_count, input ready);
    modport sink   (input valid, input is_carmichael, input is_squarefree,
                    input prime_factor_count, output ready);
endinterface

// File: sv/cmt_divider.sv
// restoring divider, one quotient bit per cycle
// depends on cmt_pkg
`timescale 1ns / 1ps

module cmt_divider import cmt_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUMBER_BITS-1:0] dividend,
    input  logic [NUMBER_BITS-1:0] divisor,
    output logic                   done,
    output logic [NUMBER_BITS-1:0] quotient,
    output logic [NUMBER_BITS-1:0] remainder
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [NUMBER_BITS-1:0] rem_reg;
    logic [NUMBER_BITS-1:0] quo_reg;
    logic [NUMBER_BITS-1:0] dvs_reg;
    logic [NUMBER_BITS:0]   trial;
    logic [NUMBER_BITS:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUMBER_BITS-1]};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_BITS'(NUMBER_BITS);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // keep the shifted partial remainder when the subtract goes negative
            rem_reg <= diff[NUMBER_BITS] ? trial[NUMBER_BITS-1:0] : diff[NUMBER_BITS-1:0];
            quo_reg <= {quo_reg[NUMBER_BITS-2:0], ~diff[NUMBER_BITS]};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: sv/cmt_datapath.sv
// datapath: cofactor, trial divisor, its square, prime count, korselt flag, result register
// depends on cmt_pkg, cmt_if, cmt_divider
`timescale 1ns / 1ps

module cmt_datapath import cmt_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [NUMBER_BITS-1:0] candidate,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    cmt_result_if.source           result
);

    logic [NUMBER_BITS-1:0]  n_reg;
    logic [NUMBER_BITS-1:0]  rest_reg;
    logic [NUMBER_BITS-1:0]  q_reg;
    logic [QSQ_BITS-1:0]     qsq_reg;
    logic [CNT_INT_BITS-1:0] count_reg;
    logic                    korselt_reg;
    logic                    out_valid_reg;
    logic                    carm_reg;
    logic                    sqf_reg;
    logic [COUNT_BITS-1:0]   cnt_reg;

    logic [NUMBER_BITS-1:0]  nm1;
    logic [NUMBER_BITS-1:0]  div_a;
    logic [NUMBER_BITS-1:0]  div_b;
    logic                    div_done;
    logic [NUMBER_BITS-1:0]  div_quo;
    logic [NUMBER_BITS-1:0]  div_rem;
    logic [COUNT_BITS-1:0]   count_sat;
    logic                    carm_final;

    assign nm1 = n_reg - 1'b1;

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_REST_Q:
            begin
                div_a = rest_reg;
                div_b = q_reg;
            end
            DIV_NM1_QM1:
            begin
                div_a = nm1;
                div_b = q_reg - 1'b1;
            end
            DIV_NM1_RESTM1:
            begin
                div_a = nm1;
                div_b = rest_reg - 1'b1;
            end
            default:
            begin
                div_a = rest_reg;
                div_b = q_reg;
            end
        endcase
    end

    cmt_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // the count saturates for the report only, the decision uses the full count
    assign count_sat  = (count_reg > CNT_INT_BITS'(COUNT_MAX)) ?
                        COUNT_BITS'(COUNT_MAX) : count_reg[COUNT_BITS-1:0];
    assign carm_final = n_reg[0] && korselt_reg &&
                        (count_reg >= CNT_INT_BITS'(MIN_PRIME_FACTORS));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg       <= candidate;
            rest_reg    <= candidate;
            q_reg       <= NUMBER_BITS'(FIRST_DIVISOR);
            qsq_reg     <= QSQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
            count_reg   <= '0;
            korselt_reg <= 1'b1;
        end
        else
        begin
            if (cmd.take_quot)
                rest_reg <= div_quo;
            if (cmd.next_q)
            begin
                // (q+1)^2 = q^2 + 2q + 1
                q_reg   <= q_reg + 1'b1;
                qsq_reg <= qsq_reg + {1'b0, q_reg, 1'b1};
            end
            if (cmd.count_inc)
                count_reg <= count_reg + 1'b1;
            if (cmd.korselt_chk && (div_rem != '0))
                korselt_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            carm_reg <= carm_final;
            sqf_reg  <= 1'b1;
            cnt_reg  <= count_sat;
        end
        else if (cmd.emit_zero)
        begin
            carm_reg <= 1'b0;
            sqf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit || cmd.emit_zero)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    assign result.valid              = out_valid_reg;
    assign result.is_carmichael      = carm_reg;
    assign result.is_squarefree      = sqf_reg;
    assign result.prime_factor_count = cnt_reg;

    always_comb
    begin
        stat.n_lt2       = (n_reg[NUMBER_BITS-1:1] == '0);
        stat.qsq_gt_rest = (qsq_reg > {2'b00, rest_reg});
        stat.rest_gt1    = (rest_reg[NUMBER_BITS-1:1] != '0);
        stat.div_done    = div_done;
        stat.rem_zero    = (div_rem == '0);
        stat.out_free    = !out_valid_reg || result.ready;
    end

endmodule

// File: sv/cmt_ctrl.sv
// controller: sequences trial division, squarefree check and korselt divisions
// depends on cmt_pkg
`timescale 1ns / 1ps

module cmt_ctrl import cmt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_CHECK;
            S_CHECK:
                state_next = stat.n_lt2 ? S_EMIT_ZERO : S_TEST;
            S_TEST:
                state_next = stat.qsq_gt_rest ? S_LAST : S_DIV1;
            S_DIV1:
                if (stat.div_done)
                    state_next = stat.rem_zero ? S_START2 : S_TEST;
            S_START2:
                state_next = S_DIV2;
            S_DIV2:
                if (stat.div_done)
                    state_next = stat.rem_zero ? S_EMIT_ZERO : S_DIV3;
            S_DIV3:
                if (stat.div_done)
                    state_next = S_TEST;
            S_LAST:
                state_next = stat.rest_gt1 ? S_DIV4 : S_EMIT;
            S_DIV4:
                if (stat.div_done)
                    state_next = S_EMIT;
            S_EMIT, S_EMIT_ZERO:
                if (stat.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.div_sel = DIV_REST_Q;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_CHECK:
            begin
            end
            S_TEST:
                cmd.div_start = !stat.qsq_gt_rest;
            S_DIV1:
                if (stat.div_done)
                begin
                    cmd.take_quot = stat.rem_zero;
                    cmd.next_q    = !stat.rem_zero;
                end
            S_START2:
                cmd.div_start = 1'b1;
            S_DIV2:
                if (stat.div_done && !stat.rem_zero)
                begin
                    // prime found once: check p-1 against n-1
                    cmd.count_inc = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_NM1_QM1;
                end
            S_DIV3:
                if (stat.div_done)
                begin
                    cmd.korselt_chk = 1'b1;
                    cmd.next_q      = 1'b1;
                end
            S_LAST:
                if (stat.rest_gt1)
                begin
                    // leftover cofactor is the largest prime
                    cmd.count_inc = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_NM1_RESTM1;
                end
            S_DIV4:
                cmd.korselt_chk = stat.div_done;
            S_EMIT:
                cmd.emit = stat.out_free;
            S_EMIT_ZERO:
                cmd.emit_zero = stat.out_free;
            default:
            begin
            end
        endcase
    end

endmodule

// File: sv/carmichael_number_tester_top.sv
// operation: one division per trial divisor q (from 2 while q*q <= cofactor), done by the
//   bit-serial divider, plus two more divisions per prime factor found that way and one more
//   for a leftover prime cofactor
// throughput: one candidate at a time; the next beat is taken once the result sits in the
//   output register, which may still be waiting on the sink
// reset: asynchronous active low, returns to idle with no result pending
`timescale 1ns / 1ps

module carmichael_number_tester_top import cmt_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    cmt_cand_if.sink     cand,
    cmt_result_if.source result
);

    cmd_t  cmd;
    stat_t stat;

    cmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cand.valid),
        .in_ready (cand.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cmt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (cand.candidate),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

// File: sv/cmt_checker.sv
// port-level checks on the carmichael number tester, bound to the top level
// depends on cmt_pkg and carmichael_number_tester_top_defines.svh
`timescale 1ns / 1ps
`include "carmichael_number_tester_top_defines.svh"

module cmt_checker import cmt_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  is_carmichael,
    input logic                  is_squarefree,
    input logic [COUNT_BITS-1:0] prime_factor_count
);

    // stalled result beat holds
    `CMT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(is_carmichael) && $stable(is_squarefree) && $stable(prime_factor_count))

    // one candidate in flight: no beat right after an accepted one
    `CMT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    `CMT_ASSERT_NOW(a_carm_sqf, out_valid && is_carmichael, is_squarefree)

    `CMT_ASSERT_NOW(a_carm_count, out_valid && is_carmichael, prime_factor_count >= COUNT_BITS'(MIN_PRIME_FACTORS))

    `CMT_ASSERT_NOW(a_not_sqf_zero, out_valid && !is_squarefree, prime_factor_count == '0)

endmodule

bind carmichael_number_tester_top cmt_checker u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (cand.valid),
    .in_ready           (cand.ready),
    .out_valid          (result.valid),
    .out_ready          (result.ready),
    .is_carmichael      (result.is_carmichael),
    .is_squarefree      (result.is_squarefree),
    .prime_factor_count (result.prime_factor_count)
);

// File: sim/carmichael_number_tester_top_test.sv
// self-checking bench for carmichael_number_tester_top: directed corner candidates, then random
// mixes of small values, known carmichael numbers, squarefree products and square multiples
// depends on cmt_pkg, cmt_if and the carmichael_number_tester_top rtl
`timescale 1ns / 1ps

module carmichael_number_tester_top_test;
    import cmt_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 8;
    localparam int IDLE_PERCENT  = 19;
    localparam int RANDOM_ITEMS  = 100;
    localparam int DRAIN_CYCLES  = 40;
    // the timeout allows the worst case, a 20-bit prime, for every item, several times over
    localparam longint unsigned TIMEOUT_NS = 64'd96_000_000;
    localparam longint unsigned FIELD_TOP  = (64'd1 << NUMBER_BITS) - 1;

    typedef struct packed {
        logic                  is_carmichael;
        logic                  is_squarefree;
        logic [COUNT_BITS-1:0] prime_factor_count;
    } verdict_t;

    logic clk;
    logic rst_n;

    cmt_cand_if   cand_ch ();
    cmt_result_if result_ch ();

    carmichael_number_tester_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cand   (cand_ch.sink),
        .result (result_ch.source)
    );

    int unsigned known_carmichael[$] = '{
        561, 1105, 1729, 2465, 2821, 6601, 8911, 10585, 15841, 29341, 41041, 46657, 52633,
        62745, 63973, 75361, 101101, 115921, 126217, 162401, 172081, 188461, 252601, 278545,
        294409, 314821, 334153, 340561, 399001, 410041, 449065, 488881, 512461, 530881,
        552721, 656601, 658801, 670033, 748657, 825265, 838201, 852841, 997633, 1024651,
        1033669
    };

    int unsigned odd_primes[$] = '{
        3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71, 73, 79, 83,
        89, 97, 101, 103, 107, 109, 113
    };

    // zero, one, tiny primes and squares, even and odd composites, the seven-prime primorial,
    // top bit alone, the largest prime in range and the all-ones value
    int unsigned edge_cases[$] = '{
        0, 1, 2, 3, 4, 9, 15, 30, 105, 561, 1105, 1729, 41041, 825265, 1024651, 510510,
        524288, 1048573, 1048574, 1048575
    };

    logic [NUMBER_BITS-1:0] candidate_queue[$];
    verdict_t               expected_verdicts[$];
    int unsigned            beats_in;
    int unsigned            fail_count;
    logic                   cand_taken;
    logic                   steady_phase;

    assign steady_phase = (beats_in >= 45) && (beats_in < 75);

    // korselt test by trial division, smallest divisor first, stopping at a repeated prime
    function automatic verdict_t judge_candidate(logic [NUMBER_BITS-1:0] value);
        longint unsigned n;
        longint unsigned rest;
        longint unsigned q;
        longint unsigned nm1;
        int unsigned     count;
        bit              korselt;
        verdict_t        v;
        n       = value;
        rest    = n;
        count   = 0;
        korselt = 1'b1;
        v       = '0;
        if (n < 2)
            return v;
        nm1 = n - 1;
        for (q = FIRST_DIVISOR; q * q <= rest; q++)
        begin
            if (rest % q == 0)
            begin
                rest = rest / q;
                if (rest % q == 0)
                    return v;
                count++;
                if (nm1 % (q - 1) != 0)
                    korselt = 1'b0;
            end
        end
        // leftover cofactor is a prime not yet counted
        if (rest > 1)
        begin
            count++;
            if (nm1 % (rest - 1) != 0)
                korselt = 1'b0;
        end
        v.is_squarefree      = 1'b1;
        v.prime_factor_count = (count > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(count);
        v.is_carmichael      = n[0] && (count >= MIN_PRIME_FACTORS) && korselt;
        return v;
    endfunction

    // mostly cheap candidates; full-width ones are rare since a large prime needs the most trial divisions
    function automatic logic [NUMBER_BITS-1:0] draw_candidate();
        int unsigned     kind;
        int unsigned     want;
        longint unsigned prod;
        longint unsigned p;
        kind = $urandom_range(0, 99);
        if (kind < 28)
            return NUMBER_BITS'($urandom_range(0, 4095));
        if (kind < 48)
            return NUMBER_BITS'(known_carmichael[$urandom_range(0, known_carmichael.size() - 1)]);
        if (kind < 65)
        begin
            // squarefree product of distinct small primes, sometimes even
            prod = ($urandom_range(0, 3) == 0) ? 2 : 1;
            want = $urandom_range(1, 6);
            repeat (want)
            begin
                p = odd_primes[$urandom_range(0, odd_primes.size() - 1)];
                if ((prod % p != 0) && (prod * p <= FIELD_TOP))
                    prod = prod * p;
            end
            return NUMBER_BITS'(prod);
        end
        if (kind < 78)
        begin
            // multiple of a prime square
            p = ($urandom_range(0, 2) == 0) ? 2 : odd_primes[$urandom_range(0, odd_primes.size() - 1)];
            prod = p * p * $urandom_range(1, int'(FIELD_TOP / (p * p)));
            return NUMBER_BITS'(prod);
        end
        if (kind < 91)
            return NUMBER_BITS'($urandom_range(0, 65535));
        return NUMBER_BITS'($urandom_range(0, int'(FIELD_TOP)));
    endfunction

    task automatic settle(input int unsigned total);
        while (beats_in != total || expected_verdicts.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // candidate driver
    always @(negedge clk)
    begin
        if (!rst_n)
            cand_ch.valid <= 1'b0;
        else if (!cand_ch.valid || cand_taken)
        begin
            if (candidate_queue.size() != 0 &&
                (steady_phase || $urandom_range(0, 99) >= IDLE_PERCENT))
            begin
                cand_ch.valid     <= 1'b1;
                cand_ch.candidate <= candidate_queue.pop_front();
            end
            else
                cand_ch.valid <= 1'b0;
        end
    end

    // result sink back-pressure
    always @(negedge clk)
        result_ch.ready <= rst_n && (steady_phase || $urandom_range(0, 99) >= IDLE_PERCENT);

    // predict on accepted candidates, check accepted results in order
    always @(posedge clk)
    begin
        verdict_t want;
        verdict_t got;
        cand_taken <= rst_n && cand_ch.valid && cand_ch.ready;
        if (rst_n)
        begin
            if (cand_ch.valid && cand_ch.ready)
            begin
                expected_verdicts.push_back(judge_candidate(cand_ch.candidate));
                beats_in++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got.is_carmichael      = result_ch.is_carmichael;
                got.is_squarefree      = result_ch.is_squarefree;
                got.prime_factor_count = result_ch.prime_factor_count;
                if (expected_verdicts.size() == 0)
                begin
                    $error("result beat with no candidate outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.is_carmichael !== want.is_carmichael)
                    begin
                        $error("is_carmichael: expected %0d, got %0d",
                               want.is_carmichael, got.is_carmichael);
                        fail_count++;
                    end
                    if (got.is_squarefree !== want.is_squarefree)
                    begin
                        $error("is_squarefree: expected %0d, got %0d",
                               want.is_squarefree, got.is_squarefree);
                        fail_count++;
                    end
                    if (got.prime_factor_count !== want.prime_factor_count)
                    begin
                        $error("prime_factor_count: expected %0d, got %0d",
                               want.prime_factor_count, got.prime_factor_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned queued;
        rst_n             = 1'b0;
        cand_ch.valid     = 1'b0;
        cand_ch.candidate = '0;
        result_ch.ready   = 1'b0;
        beats_in          = 0;
        fail_count        = 0;
        queued            = 0;

        foreach (edge_cases[i])
            candidate_queue.push_back(NUMBER_BITS'(edge_cases[i]));
        queued += edge_cases.size();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender holds off until the directed beats are fully answered
        settle(queued);

        repeat (RANDOM_ITEMS / 2)
            candidate_queue.push_back(draw_candidate());
        queued += RANDOM_ITEMS / 2;
        settle(queued);

        repeat (RANDOM_ITEMS - RANDOM_ITEMS / 2)
            candidate_queue.push_back(draw_candidate());
        queued += RANDOM_ITEMS - RANDOM_ITEMS / 2;
        settle(queued);

        // catch any stray result beats
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: carmichael_number_tester_top.f
+incdir+sv
sv/cmt_pkg.sv
sv/cmt_if.sv
sv/cmt_divider.sv
sv/cmt_datapath.sv
sv/cmt_ctrl.sv
sv/carmichael_number_tester_top.sv
sv/cmt_checker.sv
sim/carmichael_number_tester_top_test.sv
